FILE: design/bpgc_pkg.sv
// ----------------------------------------------------------------------------
// bpgc_pkg
// Shared types, codes and the byte-wide LFSR function of the bit error rate
// pattern generator and checker.
// ----------------------------------------------------------------------------
package bpgc_pkg;

    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned LFSR_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ERR_W     = 4;
    localparam int unsigned COUNT_W   = 32;

    localparam logic REG_PATTERN_MODE = 1'b0;

    localparam logic [MODE_W-1:0] MODE_MARK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPACE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALT        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONE_IN_8   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ONE_IN_16  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PRBS6      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PRBS7      = 3'd6;

    localparam logic [LFSR_W-1:0] PRBS_SEED  = 16'hAAAA;
    localparam logic [LFSR_W-1:0] PRBS6_TAPS = 16'h0021;
    localparam logic [LFSR_W-1:0] PRBS7_TAPS = 16'h0041;

    localparam logic [BYTE_W-1:0] BYTE_MARK  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ALT   = 8'hAA;
    localparam logic [BYTE_W-1:0] BYTE_PULSE = 8'h80;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
        logic              last;
    } bpgc_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  ref_byte;
        logic [ERR_W-1:0]   byte_errors;
        logic [COUNT_W-1:0] block_errors;
        logic [COUNT_W-1:0] total_errors;
    } bpgc_out_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              load;
        logic [MODE_W-1:0] load_mode;
    } bpgc_cfg_t;

    typedef struct packed {
        logic [LFSR_W-1:0] state;
        logic [BYTE_W-1:0] bits;
    } prbs_res_t;

    function automatic prbs_res_t prbs_byte(input logic [LFSR_W-1:0] state,
                                            input logic [LFSR_W-1:0] taps);
        prbs_res_t         res;
        logic [LFSR_W-1:0] s;
        logic              b;
        s = state;
        res.bits = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            b = s[0];
            s = s >> 1;
            if (b)
            begin
                s = s ^ taps;
            end
            res.bits[i] = b;
        end
        res.state = s;
        return res;
    endfunction

endpackage

FILE: design/bpgc_cfg.sv
// ----------------------------------------------------------------------------
// bpgc_cfg
// APB register slave holding the pattern mode; flags a load on each write to it.
// ----------------------------------------------------------------------------
module bpgc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpgc_pkg::PDATA_W-1:0]   prdata,
    output bpgc_pkg::bpgc_cfg_t            cfg
);
    import bpgc_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              wr_mode;

    assign wr_mode = psel && penable && pwrite && (paddr[2] == REG_PATTERN_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_mode)
        begin
            mode_next = pwdata[MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MARK;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PATTERN_MODE)
        begin
            prdata = {{(PDATA_W-MODE_W){1'b0}}, mode_reg};
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.load      = wr_mode;
    assign cfg.load_mode = pwdata[MODE_W-1:0];

endmodule

FILE: design/bpgc_pattern.sv
// ----------------------------------------------------------------------------
// bpgc_pattern
// Reference byte source: fixed patterns, the one-in-sixteen toggle and the
// PRBS6 and PRBS7 Galois LFSRs stepped eight bits per beat.
// ----------------------------------------------------------------------------
module bpgc_pattern (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpgc_pkg::bpgc_cfg_t           cfg,
    input  logic                          advance,
    output logic [bpgc_pkg::BYTE_W-1:0]   ref_byte
);
    import bpgc_pkg::*;

    logic [LFSR_W-1:0] pattern_reg;
    logic [LFSR_W-1:0] pattern_next;
    logic [LFSR_W-1:0] stepped;
    prbs_res_t         prbs6;
    prbs_res_t         prbs7;

    assign prbs6 = prbs_byte(pattern_reg, PRBS6_TAPS);
    assign prbs7 = prbs_byte(pattern_reg, PRBS7_TAPS);

    always_comb
    begin
        stepped  = pattern_reg;
        ref_byte = BYTE_SPACE;
        case (cfg.mode)
            MODE_MARK:      ref_byte = BYTE_MARK;
            MODE_SPACE:     ref_byte = BYTE_SPACE;
            MODE_ALT:       ref_byte = BYTE_ALT;
            MODE_ONE_IN_8:  ref_byte = BYTE_PULSE;
            MODE_ONE_IN_16:
            begin
                if (pattern_reg == '0)
                begin
                    ref_byte = BYTE_PULSE;
                    stepped  = LFSR_W'(1);
                end
                else
                begin
                    ref_byte = BYTE_SPACE;
                    stepped  = '0;
                end
            end
            MODE_PRBS6:
            begin
                ref_byte = prbs6.bits;
                stepped  = prbs6.state;
            end
            MODE_PRBS7:
            begin
                ref_byte = prbs7.bits;
                stepped  = prbs7.state;
            end
            default:
            begin
                ref_byte = BYTE_SPACE;
                stepped  = pattern_reg;
            end
        endcase
    end

    always_comb
    begin
        pattern_next = pattern_reg;
        if (cfg.load)
        begin
            if (cfg.load_mode inside {MODE_PRBS6, MODE_PRBS7})
            begin
                pattern_next = PRBS_SEED;
            end
            else
            begin
                pattern_next = '0;
            end
        end
        else if (advance)
        begin
            pattern_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else
        begin
            pattern_reg <= pattern_next;
        end
    end

    // Fixed patterns never disturb the state register.
    a_fixed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg.load && (cfg.mode == MODE_MARK || cfg.mode == MODE_SPACE ||
        cfg.mode == MODE_ALT || cfg.mode == MODE_ONE_IN_8) |=> $stable(pattern_reg))
        else $error("pattern state changed in a fixed pattern mode");

    // The one-in-sixteen toggle only ever holds zero or one.
    a_toggle_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg.load && cfg.mode == MODE_ONE_IN_16 |=> pattern_reg <= LFSR_W'(1))
        else $error("one-in-sixteen state out of range");

endmodule

FILE: design/bpgc_count.sv
// ----------------------------------------------------------------------------
// bpgc_count
// Bit error counting: popcount of the received byte against the reference,
// saturating per-block and running totals.
// ----------------------------------------------------------------------------
module bpgc_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  bpgc_pkg::bpgc_in_t            item,
    input  logic [bpgc_pkg::BYTE_W-1:0]   ref_byte,
    output logic [bpgc_pkg::ERR_W-1:0]    byte_errors,
    output logic [bpgc_pkg::COUNT_W-1:0]  block_sum,
    output logic [bpgc_pkg::COUNT_W-1:0]  total_sum
);
    import bpgc_pkg::*;

    logic [COUNT_W-1:0] block_count_reg;
    logic [COUNT_W-1:0] block_count_next;
    logic [COUNT_W-1:0] total_count_reg;
    logic [COUNT_W-1:0] total_count_next;
    logic [BYTE_W-1:0]  diff;
    logic [ERR_W-1:0]   ones;
    logic [COUNT_W:0]   block_wide;
    logic [COUNT_W:0]   total_wide;

    assign diff = item.rx_byte ^ ref_byte;

    always_comb
    begin
        ones = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            ones = ones + ERR_W'(diff[i]);
        end
    end

    assign byte_errors = item.op ? ones : '0;

    assign block_wide = {1'b0, block_count_reg} + (COUNT_W+1)'(byte_errors);
    assign total_wide = {1'b0, total_count_reg} + (COUNT_W+1)'(byte_errors);
    assign block_sum  = block_wide[COUNT_W] ? '1 : block_wide[COUNT_W-1:0];
    assign total_sum  = total_wide[COUNT_W] ? '1 : total_wide[COUNT_W-1:0];

    always_comb
    begin
        block_count_next = block_count_reg;
        total_count_next = total_count_reg;
        if (advance)
        begin
            block_count_next = item.last ? '0 : block_sum;
            total_count_next = total_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
            total_count_reg <= '0;
        end
        else
        begin
            block_count_reg <= block_count_next;
            total_count_reg <= total_count_next;
        end
    end

    // The block count restarts after the beat that closes a block.
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last |=> block_count_reg == '0)
        else $error("block count not cleared after last beat");

    // The running total never goes backwards.
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> total_count_reg >= $past(total_count_reg))
        else $error("total error count decreased");

endmodule

FILE: design/ber_pattern_gen_checker.sv
// ----------------------------------------------------------------------------
// ber_pattern_gen_checker
// Bit error rate tester: generates a reference byte pattern and, in check
// mode, counts bit errors in received bytes per block and in total.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_ready    in_data  (op, rx_byte, last)
//   out       source     out_valid/out_ready  out_data (ref_byte, errors)
//   apb       slave      psel/penable/pready  pattern_mode at address 0
//
// One beat per cycle is sustained while out_ready holds; a beat is captured in the
// input register and moves on to the result register, which presents its result.
// Reset clears the pattern state, both counters and the mode (to mark, all ones).
// A stalled output holds its result while one more beat waits in the input
// register; ready falls only when both registers are full.
// ----------------------------------------------------------------------------
module ber_pattern_gen_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpgc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bpgc_pkg::bpgc_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bpgc_pkg::bpgc_out_t            out_data
);
    import bpgc_pkg::*;

    bpgc_cfg_t          cfg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    bpgc_in_t           s1_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    bpgc_out_t          out_data_reg;
    bpgc_out_t          result;
    logic               advance;
    logic               accept;
    logic [BYTE_W-1:0]  ref_byte;
    logic [ERR_W-1:0]   byte_errors;
    logic [COUNT_W-1:0] block_sum;
    logic [COUNT_W-1:0] total_sum;

    assign pready = 1'b1;

    bpgc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bpgc_pattern u_pattern (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .advance  (advance),
        .ref_byte (ref_byte)
    );

    bpgc_count u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (s1_data_reg),
        .ref_byte    (ref_byte),
        .byte_errors (byte_errors),
        .block_sum   (block_sum),
        .total_sum   (total_sum)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign result.ref_byte     = ref_byte;
    assign result.byte_errors  = byte_errors;
    assign result.block_errors = block_sum;
    assign result.total_errors = total_sum;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A byte can never show more errors than it has bits.
    a_byte_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.byte_errors <= ERR_W'(BYTE_W))
        else $error("byte error count exceeds byte width");

    // Errors of the current block are a subset of all errors.
    a_block_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.block_errors <= out_data.total_errors)
        else $error("block errors exceed total errors");

    // A waiting beat moves on as soon as the result register frees up.
    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending beat did not reach the result register");

endmodule

FILE: bench/ber_pattern_gen_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_pattern_gen_checker_test
// Self-checking bench for the bit error rate pattern generator and checker.
// A queue-fed driver offers beats in random bursts while a monitor stalls the
// result side on its own pattern. Every accepted beat is run through a local
// model of the pattern source and error counters, and each result beat is
// compared field by field with the oldest prediction. Directed beats cover
// every pattern mode, the unused mode, block ends and error extremes; random
// phases then change the mode between drained runs of mixed traffic.
// ----------------------------------------------------------------------------
module ber_pattern_gen_checker_test;

    import bpgc_pkg::*;

    localparam int unsigned CLK_HALF    = 5;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned RANDOM_BEATS = 1150;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned PRINT_LIMIT = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    bpgc_in_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    bpgc_out_t            out_data;

    // Local copy of the block's state.
    logic [MODE_W-1:0]    mode_now = MODE_MARK;
    logic [LFSR_W-1:0]    lfsr_now = '0;
    logic [COUNT_W-1:0]   block_sum = '0;
    logic [COUNT_W-1:0]   total_sum = '0;

    bpgc_in_t             beat_q[$];
    bpgc_out_t            pattern_result_q[$];

    int unsigned          cycle_count = 0;
    int unsigned          fail_count = 0;
    int unsigned          burst_left = 0;
    int unsigned          gap_left = 0;
    int unsigned          hold_left = 0;
    logic                 hold_request = 1'b0;
    int unsigned          stall_style = 0;
    logic [7:0]           stall_mask = 8'h01;
    bpgc_out_t            want;

    ber_pattern_gen_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic [BYTE_W-1:0] lfsr_byte(input logic [LFSR_W-1:0] taps);
        logic [BYTE_W-1:0] bits;
        logic              b;
        bits = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            b = lfsr_now[0];
            lfsr_now = lfsr_now >> 1;
            if (b)
            begin
                lfsr_now = lfsr_now ^ taps;
            end
            bits[i] = b;
        end
        return bits;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_sum(input logic [COUNT_W-1:0] a,
                                                   input logic [ERR_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + (COUNT_W+1)'(b);
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    function automatic bpgc_out_t next_pattern_result(input bpgc_in_t beat);
        bpgc_out_t res;
        res = '0;
        case (mode_now)
            MODE_MARK:      res.ref_byte = BYTE_MARK;
            MODE_SPACE:     res.ref_byte = BYTE_SPACE;
            MODE_ALT:       res.ref_byte = BYTE_ALT;
            MODE_ONE_IN_8:  res.ref_byte = BYTE_PULSE;
            MODE_ONE_IN_16:
            begin
                if (lfsr_now == '0)
                begin
                    lfsr_now = LFSR_W'(1);
                    res.ref_byte = BYTE_PULSE;
                end
                else
                begin
                    lfsr_now = '0;
                    res.ref_byte = BYTE_SPACE;
                end
            end
            MODE_PRBS6:     res.ref_byte = lfsr_byte(PRBS6_TAPS);
            MODE_PRBS7:     res.ref_byte = lfsr_byte(PRBS7_TAPS);
            default:        res.ref_byte = '0;
        endcase
        if (beat.op)
        begin
            res.byte_errors = ERR_W'($countones(beat.rx_byte ^ res.ref_byte));
            block_sum = sat_sum(block_sum, res.byte_errors);
            total_sum = sat_sum(total_sum, res.byte_errors);
        end
        res.block_errors = block_sum;
        res.total_errors = total_sum;
        if (beat.last)
        begin
            block_sum = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] exp_val);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("Mismatch in %s at cycle %0d: got 0x%0h, expected 0x%0h",
                     what, cycle_count, got, exp_val);
        end
        fail_count++;
    endtask

    // Driver: bursts of beats separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pattern_result_q.push_back(next_pattern_result(in_data));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    in_data <= beat_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and stalls on its own pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pattern_result_q.size() == 0)
                begin
                    report_mismatch("unexpected result beat",
                                    COUNT_W'(out_data.ref_byte), '0);
                end
                else
                begin
                    want = pattern_result_q.pop_front();
                    if (out_data.ref_byte !== want.ref_byte)
                    begin
                        report_mismatch("ref_byte", COUNT_W'(out_data.ref_byte),
                                        COUNT_W'(want.ref_byte));
                    end
                    if (out_data.byte_errors !== want.byte_errors)
                    begin
                        report_mismatch("byte_errors", COUNT_W'(out_data.byte_errors),
                                        COUNT_W'(want.byte_errors));
                    end
                    if (out_data.block_errors !== want.block_errors)
                    begin
                        report_mismatch("block_errors", out_data.block_errors,
                                        want.block_errors);
                    end
                    if (out_data.total_errors !== want.total_errors)
                    begin
                        report_mismatch("total_errors", out_data.total_errors,
                                        want.total_errors);
                    end
                end
            end
            if (cycle_count % 96 == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_mask = 8'($urandom) | 8'h01;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (stall_style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= stall_mask[cycle_count % 8];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[MODE_W-1:0] = mode;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PATTERN_MODE, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        mode_now = mode;
        lfsr_now = (mode == MODE_PRBS6 || mode == MODE_PRBS7) ? PRBS_SEED : '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (beat_q.size() != 0 || in_valid || pattern_result_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic bpgc_in_t random_beat();
        bpgc_in_t b;
        b.op = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 7))
            0:       b.rx_byte = 8'h00;
            1:       b.rx_byte = 8'hFF;
            2:       b.rx_byte = 8'hAA;
            3:       b.rx_byte = 8'h55;
            4:       b.rx_byte = 8'h80;
            default: b.rx_byte = 8'($urandom);
        endcase
        b.last = ($urandom_range(0, 15) == 0);
        return b;
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned count;
        logic [MODE_W-1:0] mode;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: every mode including the unused one, error extremes and
        // block ends in both generate and check mode.
        for (int m = 0; m < 8; m++)
        begin
            if (m != 0)
            begin
                write_mode(MODE_W'(m));
            end
            beat_q.push_back('{op: 1'b1, rx_byte: 8'h00, last: 1'b0});
            beat_q.push_back('{op: 1'b1, rx_byte: 8'hFF, last: 1'b1});
            beat_q.push_back('{op: 1'b0, rx_byte: 8'($urandom), last: 1'b1});
            wait_drained();
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (phase < 8)
            begin
                mode = MODE_W'(7 - phase);
            end
            else
            begin
                mode = MODE_W'($urandom_range(0, 7));
            end
            write_mode(mode);
            count = (phase % 5 == 4) ? 8 : $urandom_range(40, 120);
            for (int i = 0; i < count; i++)
            begin
                beat_q.push_back(random_beat());
            end
            sent += count;
            if (phase == 3 || phase == 9)
            begin
                hold_request = 1'b1;
            end
            wait_drained();
            phase++;
        end

        repeat (SETTLE) @(posedge clk);
        if (pattern_result_q.size() != 0)
        begin
            report_mismatch("results still pending", pattern_result_q.size(), 0);
        end
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bpgc_pkg.sv
design/bpgc_cfg.sv
design/bpgc_pattern.sv
design/bpgc_count.sv
design/ber_pattern_gen_checker.sv
bench/ber_pattern_gen_checker_test.sv
